/* src/multilevel_page_table_walk_top_assert.svh */
// Assertion helpers for the page table walker.
`ifndef MULTILEVEL_PAGE_TABLE_WALK_TOP_ASSERT_SVH
`define MULTILEVEL_PAGE_TABLE_WALK_TOP_ASSERT_SVH

// Check that post holds in the same cycle as pre.
`define MLPTW_CHECK_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Check that post holds in the cycle after pre.
`define MLPTW_CHECK_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

/* src/mlptw_pkg.sv */
package mlptw_pkg;

   // request kinds carried in req_tuser
   localparam logic OP_WRITE     = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_LEVEL_SHIFT = 2'd0;
   localparam logic [1:0] CSR_LEVEL_WIDTH = 2'd1;
   localparam logic [1:0] CSR_ROOT_BASE   = 2'd2;

   localparam logic [29:0] LEVEL_SHIFT_RESET = 30'd662262534;
   localparam logic [29:0] LEVEL_WIDTH_RESET = 30'd153391680;
   localparam logic [11:0] ROOT_BASE_RESET   = 12'd0;

   // entry bits
   localparam int unsigned LEAF_BIT  = 0;
   localparam int unsigned VALID_BIT = 7;
   localparam logic [63:0] PAGE_MASK = 64'hFFFF_FFFF_FFFF_F000;

   typedef struct packed {
      logic [5:0] shift;
      logic [5:0] width;
   } lvl_desc_type;

   // six-bit slot of a packed level word, level 0 in the top bits
   function automatic logic [5:0] slot_of(input logic [29:0] word, input logic [1:0] lvl);
      logic [5:0] slot;
      unique case (lvl)
         2'd0: slot = word[29:24];
         2'd1: slot = word[23:18];
         2'd2: slot = word[17:12];
         2'd3: slot = word[11:6];
         default: slot = 6'd0;
      endcase
      return slot;
   endfunction

endpackage

/* src/mlptw_table_mem.sv */
module mlptw_table_mem
#(
   parameter int AW = 12
)
(
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data
);

   logic [63:0] mem_ff [2**AW];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mlptw_index_unit.sv */
module mlptw_index_unit
   import mlptw_pkg::*;
#(
   parameter int AW = 12
)
(
   input  logic [63:0]   vaddr,
   input  lvl_desc_type  desc,
   input  logic [AW-1:0] table_start,
   output logic [AW-1:0] entry_addr
);

   logic [63:0]   shifted;
   logic [AW-1:0] idx;

   always_comb begin
      shifted = vaddr >> desc.shift;
      // only the index bits below the level width and the memory depth survive the wrap
      for (int i = 0; i < AW; i++) begin
         idx[i] = shifted[i] & (i < int'(desc.width));
      end
      entry_addr = table_start + idx;
   end

endmodule

/* src/multilevel_page_table_walk_top.sv */
// Channel   Dir  Handshake                 Payload
// req_      in   req_tvalid/req_tready     tdata: mem_index, mem_data, vaddr; tuser: op
// rsp_      out  rsp_tvalid/rsp_tready     tdata: paddr; tuser: fault
// csr_      in   csr_valid/csr_ready       csr_index, csr_data
//
// A table write is done in the cycle in which it is accepted. A translation has a setup
// step and a result step, plus for each level used an index add and memory read, then an
// entry check, and for each skipped level only a level advance.
// Reset is synchronous; table memory is not cleared and needs no clearing pass.
// The result sits in an output register; a stalled result holds the next walk in its
// result cycle, and the input stays blocked until the register drains.
// TABLE_WORDS must be a power of two.
module multilevel_page_table_walk_top
   import mlptw_pkg::*;
#(
   parameter int TABLE_WORDS = 4096,
   parameter int MAX_LEVELS  = 4
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,  // mem_index[11:0], mem_data[75:12], vaddr[139:76]
   input  logic [0:0]   req_tuser,  // op[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // paddr[63:0]
   output logic [0:0]   rsp_tuser,  // fault[0]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [29:0]  csr_data
);

   localparam int AW = $clog2(TABLE_WORDS);
   localparam logic [1:0] LAST_LVL = 2'(MAX_LEVELS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_EVAL,
      ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [1:0]    lvl_ff, lvl_in;
   logic [AW-1:0] start_ff, start_in;
   logic [63:0]   virt_ff, virt_in;
   logic [5:0]    last_shift_ff, last_shift_in;
   logic          any_ff, any_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   phys_ff, phys_in;
   logic          fault_ff, fault_in;

   logic [29:0]   shift_word_ff;
   logic [29:0]   width_word_ff;
   logic [11:0]   root_ff;

   lvl_desc_type  desc;
   logic [AW-1:0] entry_addr;
   logic [63:0]   rd_data;
   logic          rd_en;
   logic          wr_en;
   logic          req_accept;
   logic          page_ok;
   logic [63:0]   off_mask;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign wr_en      = req_accept && (req_tuser[0] == OP_WRITE);
   assign csr_ready  = 1'b1;

   assign desc  = '{shift: slot_of(shift_word_ff, lvl_ff), width: slot_of(width_word_ff, lvl_ff)};
   assign rd_en = (state_ff == ST_STEP) && (desc.width != 6'd0);

   mlptw_index_unit #(.AW(AW)) u_index (
      .vaddr       (virt_ff),
      .desc        (desc),
      .table_start (start_ff),
      .entry_addr  (entry_addr)
   );

   mlptw_table_mem #(.AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_tdata[11:0])),
      .wr_data (req_tdata[75:12]),
      .rd_en   (rd_en),
      .rd_addr (entry_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_word_ff <= LEVEL_SHIFT_RESET;
         width_word_ff <= LEVEL_WIDTH_RESET;
         root_ff       <= ROOT_BASE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LEVEL_SHIFT: shift_word_ff <= csr_data;
            CSR_LEVEL_WIDTH: width_word_ff <= csr_data;
            CSR_ROOT_BASE:   root_ff       <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 64; i++) begin
         off_mask[i] = (i < int'(last_shift_ff));
      end
      page_ok = any_ff && rd_data[VALID_BIT];
   end

   always_comb begin
      state_in      = state_ff;
      lvl_in        = lvl_ff;
      start_in      = start_ff;
      virt_in       = virt_ff;
      last_shift_in = last_shift_ff;
      any_in        = any_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      phys_in       = phys_ff;
      fault_in      = fault_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser[0] == OP_TRANSLATE)) begin
               virt_in  = req_tdata[139:76];
               start_in = AW'(root_ff);
               lvl_in   = 2'd0;
               any_in   = 1'b0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (desc.width != 6'd0) begin
               last_shift_in = desc.shift;
               any_in        = 1'b1;
               state_in      = ST_EVAL;
            end else if (lvl_ff == LAST_LVL) begin
               state_in = ST_FINISH;
            end else begin
               lvl_in = lvl_ff + 2'd1;
            end
         end
         ST_EVAL: begin
            if (rd_data[LEAF_BIT] || (lvl_ff == LAST_LVL)) begin
               state_in = ST_FINISH;
            end else begin
               // follow the byte pointer to the next table
               start_in = rd_data[AW+2:3];
               lvl_in   = lvl_ff + 2'd1;
               state_in = ST_STEP;
            end
         end
         ST_FINISH: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               fault_in     = !page_ok;
               phys_in      = page_ok ? ((rd_data & PAGE_MASK) | (virt_ff & off_mask)) : 64'd0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lvl_ff        <= lvl_in;
      start_ff      <= start_in;
      virt_ff       <= virt_in;
      last_shift_ff <= last_shift_in;
      any_ff        <= any_in;
      phys_ff       <= phys_in;
      fault_ff      <= fault_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = phys_ff;
   assign rsp_tuser[0] = fault_ff;

`include "multilevel_page_table_walk_top_assert.svh"

   `MLPTW_CHECK_NOW(a_fault_zero_addr, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == 64'd0, "fault result carries a nonzero address")
   `MLPTW_CHECK_NOW(a_no_rd_on_wr, clock, reset, wr_en, !rd_en, "table read and write in the same cycle")
   `MLPTW_CHECK_NEXT(a_walk_start, clock, reset, req_accept && (req_tuser[0] == OP_TRANSLATE), (state_ff == ST_STEP) && (lvl_ff == 2'd0) && !any_ff, "walk did not start at level zero")
   `MLPTW_CHECK_NEXT(a_walk_descend, clock, reset, (state_ff == ST_EVAL) && !rd_data[LEAF_BIT] && (lvl_ff != LAST_LVL), (state_ff == ST_STEP) && (lvl_ff == $past(lvl_ff) + 2'd1), "pointer entry did not advance the level")

endmodule
